@@ rtl/periodic_timer_catchup_limit_macros.svh @@
// Assertion macros for the periodic timer block.
// Included by the top level; no other dependencies.
`ifndef PERIODIC_TIMER_CATCHUP_LIMIT_MACROS_SVH
`define PERIODIC_TIMER_CATCHUP_LIMIT_MACROS_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define PTCL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ptcl: assertion failed");
// Checked at every edge, reset included.
`define PTCL_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("ptcl: assertion failed");
`else
`define PTCL_ASSERT(lbl, prop)
`define PTCL_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ rtl/ptcl_pkg.sv @@
// Shared types and constants for the periodic timer block.
// No dependencies.
package ptcl_pkg;

    localparam int CLK_W    = 48;
    localparam int PERIOD_W = 32;
    localparam int COUNT_W  = 16;
    localparam int SLEEP_W  = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(1000);
    localparam logic [COUNT_W-1:0]  MAX_CATCHUP_RST = COUNT_W'(1);

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ARM    = 2'd1,
        OP_DISARM = 2'd2
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD      = 2'd0,
        CFG_REPEAT      = 2'd1,
        CFG_MAX_CATCHUP = 2'd2
    } t_cfg_idx;

    // Controller -> datapath
    typedef struct packed {
        logic capture;   // latch input item
        logic exec;      // apply arm / disarm
        logic step;      // one catch-up iteration
        logic load_out;  // write result register
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic is_tick;
        logic run_done;  // current iteration is the last one
        logic slot_free; // result register can take a new result
    } t_dp_stat;

endpackage

@@ rtl/periodic_timer_catchup_limit.sv @@
// Periodic / one-shot timer with catch-up limit, top level.
// Depends on ptcl_pkg, ptcl_ctrl, ptcl_datapath and the macros header.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one item: opcode
//   (tick, arm, disarm), the current 48-bit microsecond clock, the sleep
//   hint so far and the delegate-gone flag. Each item yields exactly one
//   result on the output channel (o_out_valid / i_out_ready): firing
//   count, expired flag and updated sleep hint.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready) writes
//   period, repeat mode and catch-up limit; write only while idle.
// Sequence:
//   Each item passes the execute state and then the done state, where the
//   result is loaded once the output register is free; a tick runs the
//   catch-up loop in between, which ends on nothing due, a gone delegate,
//   a one-shot stop or the catch-up limit, so at most that limit is counted.
//   Input ready returns in the cycle after the result is loaded; one item at a time.
// Reset: timer disarmed, deadline zero, config back to period 1000,
//   one-shot, limit 1; output channel empty.
// Stall: a result waits in the output register; the next item can be
//   taken meanwhile and its result is held in the datapath until the
//   output register frees up.
`include "periodic_timer_catchup_limit_macros.svh"

module periodic_timer_catchup_limit import ptcl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input item channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_opcode,
    input  logic [CLK_W-1:0]      i_now_us,
    input  logic [SLEEP_W-1:0]    i_sleep_in_us,
    input  logic                  i_delegate_gone,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [COUNT_W-1:0]    o_fire_count,
    output logic                  o_expired,
    output logic [SLEEP_W-1:0]    o_sleep_out_us
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // config registers take a write every cycle
    assign o_cfg_ready = 1'b1;

    ptcl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ptcl_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (i_opcode),
        .i_now_us        (i_now_us),
        .i_sleep_in_us   (i_sleep_in_us),
        .i_delegate_gone (i_delegate_gone),
        .i_out_ready     (i_out_ready),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_out_valid     (o_out_valid),
        .o_fire_count    (o_fire_count),
        .o_expired       (o_expired),
        .o_sleep_out_us  (o_sleep_out_us)
    );

    // an accepted item is followed by the execute step, and no second transfer
    `PTCL_ASSERT(a_accept_exec, (i_in_valid && o_in_ready) |=> (cmd.exec && !o_in_ready))
    // a result is only written when the output register is free
    `PTCL_ASSERT_ALWAYS(a_load_slot, cmd.load_out |-> (!o_out_valid || i_out_ready))
    // catch-up steps never overlap the input side
    `PTCL_ASSERT(a_step_busy, cmd.step |-> (!o_in_ready && !cmd.exec))

endmodule

@@ rtl/ptcl_ctrl.sv @@
// Sequencer for the periodic timer: accept, execute, catch-up loop, result.
// Depends on ptcl_pkg.
module ptcl_ctrl import ptcl_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RUN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.capture = i_in_valid && r_in_ready;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.capture) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = i_stat.is_tick ? S_RUN : S_DONE;
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_stat.run_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

@@ rtl/ptcl_datapath.sv @@
// Timer datapath: config registers, deadline/armed state, catch-up step,
// sleep hint and result register. Depends on ptcl_pkg.
module ptcl_datapath import ptcl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [1:0]            i_opcode,
    input  logic [CLK_W-1:0]      i_now_us,
    input  logic [SLEEP_W-1:0]    i_sleep_in_us,
    input  logic                  i_delegate_gone,
    input  logic                  i_out_ready,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output logic                  o_out_valid,
    output logic [COUNT_W-1:0]    o_fire_count,
    output logic                  o_expired,
    output logic [SLEEP_W-1:0]    o_sleep_out_us
);

    // configuration
    logic [PERIOD_W-1:0] r_period;
    logic                r_repeat;
    logic [COUNT_W-1:0]  r_max_catchup;

    // latched item
    t_opcode             r_op;
    logic [CLK_W-1:0]    r_now;
    logic [SLEEP_W-1:0]  r_sleep;
    logic                r_gone;

    // timer state and per-tick work
    logic [CLK_W-1:0]    r_deadline;
    logic                r_armed;
    logic [COUNT_W-1:0]  r_count;
    logic                r_exp;

    // result register
    logic                r_out_valid;
    logic [COUNT_W-1:0]  r_out_count;
    logic                r_out_exp;
    logic [SLEEP_W-1:0]  r_out_sleep;

    logic [COUNT_W-1:0]  limit;
    logic [COUNT_W:0]    count_inc;
    logic                hit;
    logic                due;
    logic                use_now;
    logic [CLK_W-1:0]    sum;
    logic [CLK_W-1:0]    diff;
    logic [SLEEP_W-1:0]  to_deadline;
    logic [SLEEP_W-1:0]  hint;

    always_comb begin
        limit     = (r_max_catchup == '0) ? MAX_CATCHUP_RST : r_max_catchup;
        count_inc = {1'b0, r_count} + (COUNT_W+1)'(1);
        hit       = count_inc >= {1'b0, limit};
        due       = r_armed && (r_deadline < r_now);
        // arm and catch-up restart both take now + period
        use_now   = (i_cmd.exec && (r_op == OP_ARM)) || (r_repeat && hit);
        sum       = (use_now ? r_now : r_deadline) + CLK_W'(r_period);
    end

    // sleep hint: sleep_in when disarmed, else min(sleep_in, saturated time to deadline)
    always_comb begin
        diff = r_deadline - r_now;
        if (r_deadline <= r_now) begin
            to_deadline = '0;
        end else if (diff[CLK_W-1:SLEEP_W] != '0) begin
            to_deadline = '1;
        end else begin
            to_deadline = diff[SLEEP_W-1:0];
        end
        if (!r_armed || (r_sleep < to_deadline)) begin
            hint = r_sleep;
        end else begin
            hint = to_deadline;
        end
    end

    always_comb begin
        o_stat.is_tick   = (r_op == OP_TICK);
        o_stat.run_done  = !due || r_gone || !r_repeat || hit;
        o_stat.slot_free = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period      <= PERIOD_RST;
            r_repeat      <= 1'b0;
            r_max_catchup <= MAX_CATCHUP_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PERIOD:      r_period      <= i_cfg_data[PERIOD_W-1:0];
                CFG_REPEAT:      r_repeat      <= i_cfg_data[0];
                CFG_MAX_CATCHUP: r_max_catchup <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= t_opcode'(i_opcode);
            r_now   <= i_now_us;
            r_sleep <= i_sleep_in_us;
            r_gone  <= i_delegate_gone;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadline <= '0;
            r_armed    <= 1'b0;
            r_count    <= '0;
            r_exp      <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_count <= '0;
                r_exp   <= 1'b0;
            end
            if (i_cmd.exec) begin
                case (r_op)
                    OP_ARM: begin
                        r_deadline <= sum;
                        r_armed    <= 1'b1;
                    end
                    OP_DISARM: begin
                        r_armed <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.step && due) begin
                if (r_gone) begin
                    r_armed <= 1'b0;
                    r_exp   <= 1'b1;
                end else begin
                    r_count <= count_inc[COUNT_W-1:0];
                    if (!r_repeat) begin
                        // one-shot: stop, deadline left as is
                        r_armed <= 1'b0;
                        r_exp   <= 1'b1;
                    end else begin
                        r_deadline <= sum;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_count <= r_count;
            r_out_exp   <= r_exp;
            r_out_sleep <= hint;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_fire_count   = r_out_count;
    assign o_expired      = r_out_exp;
    assign o_sleep_out_us = r_out_sleep;

endmodule
